/* hw/rtl/lbc_pkg.sv */
package lbc_pkg;

  localparam int unsigned SlotsDef   = 32;
  localparam int unsigned RefBitsDef = 8;

  localparam int unsigned DevW  = 8;
  localparam int unsigned BlkW  = 32;
  localparam int unsigned SlotW = 5;
  localparam int unsigned RefsW = 8;
  localparam int unsigned StW   = 2;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_REL = 1'b1;

  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_NOFREE = 2'd1;
  localparam logic [StW-1:0] ST_UNREF  = 2'd2;
  localparam logic [StW-1:0] ST_OVF    = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INCR,
    KIND_RETAG,
    KIND_DECR,
    KIND_MOVE
  } kind_e;

  typedef struct packed {
    logic             op;
    logic [DevW-1:0]  device;
    logic [BlkW-1:0]  block_number;
    logic [SlotW-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             need_fill;
    logic [StW-1:0]   status;
    logic [RefsW-1:0] refs_after;
  } rsp_t;

  typedef struct packed {
    kind_e           kind;
    logic [DevW-1:0] device;
    logic [BlkW-1:0] block_number;
  } cmd_t;

endpackage

/* hw/rtl/lbc_cell.sv */
module lbc_cell import lbc_pkg::*; #(
  parameter int unsigned SLOTS    = SlotsDef,
  parameter int unsigned REF_BITS = RefBitsDef,
  parameter int unsigned POS      = 0,
  localparam int unsigned IdW     = $clog2(SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                eval_i,
  input  logic                apply_i,
  input  cmd_t                cmd_i,
  input  logic [IdW-1:0]      rel_id_i,
  input  logic                sel_i,
  input  logic                shift_i,
  input  logic [IdW-1:0]      nb_id_i,
  input  logic [DevW-1:0]     nb_dev_i,
  input  logic [BlkW-1:0]     nb_blk_i,
  input  logic                nb_vld_i,
  input  logic [REF_BITS-1:0] nb_cnt_i,
  output logic [IdW-1:0]      id_o,
  output logic [DevW-1:0]     dev_o,
  output logic [BlkW-1:0]     blk_o,
  output logic                vld_o,
  output logic [REF_BITS-1:0] cnt_o,
  output logic                match_o,
  output logic                zero_o,
  output logic                idhit_o
);

  logic [IdW-1:0]      id_q;
  logic [DevW-1:0]     dev_q;
  logic [BlkW-1:0]     blk_q;
  logic                vld_q;
  logic [REF_BITS-1:0] cnt_q;
  logic                match_q, zero_q, idhit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= IdW'(POS);
      dev_q   <= '0;
      blk_q   <= '0;
      vld_q   <= 1'b0;
      cnt_q   <= '0;
      match_q <= 1'b0;
      zero_q  <= 1'b0;
      idhit_q <= 1'b0;
    end else begin
      if (eval_i) begin
        match_q <= (dev_q == cmd_i.device) && (blk_q == cmd_i.block_number);
        zero_q  <= (cnt_q == '0);
        idhit_q <= (id_q == rel_id_i);
      end
      if (apply_i) begin
        if (shift_i) begin
          id_q  <= nb_id_i;
          dev_q <= nb_dev_i;
          blk_q <= nb_blk_i;
          vld_q <= nb_vld_i;
          cnt_q <= nb_cnt_i;
        end else if (sel_i) begin
          case (cmd_i.kind)
            KIND_INCR: begin
              cnt_q <= cnt_q + 1'b1;
              vld_q <= 1'b1;
            end
            KIND_RETAG: begin
              dev_q <= cmd_i.device;
              blk_q <= cmd_i.block_number;
              cnt_q <= REF_BITS'(1);
              vld_q <= 1'b1;
            end
            KIND_DECR: cnt_q <= cnt_q - 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  assign id_o    = id_q;
  assign dev_o   = dev_q;
  assign blk_o   = blk_q;
  assign vld_o   = vld_q;
  assign cnt_o   = cnt_q;
  assign match_o = match_q;
  assign zero_o  = zero_q;
  assign idhit_o = idhit_q;

endmodule

/* hw/rtl/lru_block_buffer_cache.sv */
// Buffer cache directory with reference counts and LRU replacement.
// Request channel: in_valid_i / in_stall_o carrying in_req_i (op, device,
// block_number, slot_in). Response channel: out_valid_o / out_stall_i
// carrying out_rsp_o (slot, need_fill, status, refs_after). Every request
// gives exactly one response.
// Slots live in a chain of cells ordered by recency, least recent at the
// bottom. After a request is accepted, every cell compares its tag, count
// and slot id in the compare state; in the update state the block picks a
// cell by priority, updates it and registers the response. A release that
// drops a count to zero shifts the cells above the slot down by one and puts
// the slot at the top in that same cycle.
// One request is in flight at a time, so a new request is not taken until
// the last is done; the response register frees the block while a response
// waits. If the receiver stalls, the response holds and the next request
// waits in its update cycle until the register is taken.
// Reset clears all tags, valid marks and counts and orders slot i at
// rank i; the block takes requests as soon as reset is released.
module lru_block_buffer_cache import lbc_pkg::*; #(
  parameter int unsigned SLOTS    = SlotsDef,
  parameter int unsigned REF_BITS = RefBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IdW = $clog2(SLOTS);
  localparam logic [REF_BITS-1:0] RefMax = '1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  req_t       req_q;
  logic       out_valid_q;
  rsp_t       out_rsp_q;

  logic [IdW-1:0]      c_id  [SLOTS];
  logic [DevW-1:0]     c_dev [SLOTS];
  logic [BlkW-1:0]     c_blk [SLOTS];
  logic                c_vld [SLOTS];
  logic [REF_BITS-1:0] c_cnt [SLOTS];
  logic [SLOTS-1:0]    match, zero, idhit, sel, shift;

  cmd_t           cmd;
  logic [IdW-1:0] rel_id;
  logic           apply_go;
  logic           hit_any, free_any, rel_any;
  logic [IdW-1:0] hit_pos, free_pos, rel_pos, sel_pos;
  logic           rel_range;
  logic [REF_BITS-1:0] s_cnt;
  logic [15:0]    refs_w;
  rsp_t           rsp;

  assign rel_id    = IdW'(req_q.slot_in);
  assign rel_range = 32'(req_q.slot_in) < SLOTS;
  assign apply_go  = (state_q == S_APPLY) && !(out_valid_q && out_stall_i);

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    rel_any  = 1'b0;
    hit_pos  = '0;
    free_pos = '0;
    rel_pos  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_pos = IdW'(i);
      end
      if (idhit[i]) begin
        rel_any = 1'b1;
        rel_pos = IdW'(i);
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (zero[i]) begin
        free_any = 1'b1;
        free_pos = IdW'(i);
      end
    end
  end

  always_comb begin
    if (req_q.op == OP_REL) begin
      sel_pos = rel_pos;
    end else if (hit_any) begin
      sel_pos = hit_pos;
    end else begin
      sel_pos = free_pos;
    end
  end

  assign s_cnt = c_cnt[sel_pos];

  always_comb begin
    cmd.device       = req_q.device;
    cmd.block_number = req_q.block_number;
    cmd.kind         = KIND_NONE;
    rsp.slot         = SlotW'(c_id[sel_pos]);
    rsp.need_fill    = 1'b0;
    rsp.status       = ST_OK;
    refs_w           = '0;
    if (req_q.op == OP_REL) begin
      if (!rel_range || !rel_any || s_cnt == '0) begin
        rsp.slot   = req_q.slot_in;
        rsp.status = ST_UNREF;
      end else begin
        cmd.kind = (s_cnt == REF_BITS'(1)) ? KIND_MOVE : KIND_DECR;
        refs_w   = 16'(s_cnt - 1'b1);
      end
    end else if (hit_any) begin
      if (s_cnt == RefMax) begin
        rsp.status = ST_OVF;
        refs_w     = 16'(s_cnt);
      end else begin
        cmd.kind      = KIND_INCR;
        rsp.need_fill = !c_vld[sel_pos];
        refs_w        = 16'(s_cnt + 1'b1);
      end
    end else if (free_any) begin
      cmd.kind      = KIND_RETAG;
      rsp.need_fill = 1'b1;
      refs_w        = 16'd1;
    end else begin
      rsp.slot   = '0;
      rsp.status = ST_NOFREE;
    end
    rsp.refs_after = refs_w[RefsW-1:0];
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      sel[i]   = (cmd.kind != KIND_NONE) && (IdW'(i) == sel_pos);
      shift[i] = (cmd.kind == KIND_MOVE) && (IdW'(i) >= sel_pos);
    end
  end

  for (genvar p = 0; p < SLOTS; p++) begin : g_cell
    logic [IdW-1:0]      nb_id;
    logic [DevW-1:0]     nb_dev;
    logic [BlkW-1:0]     nb_blk;
    logic                nb_vld;
    logic [REF_BITS-1:0] nb_cnt;

    if (p == SLOTS - 1) begin : g_top
      assign nb_id  = c_id[sel_pos];
      assign nb_dev = c_dev[sel_pos];
      assign nb_blk = c_blk[sel_pos];
      assign nb_vld = c_vld[sel_pos];
      assign nb_cnt = '0;
    end else begin : g_mid
      assign nb_id  = c_id[p+1];
      assign nb_dev = c_dev[p+1];
      assign nb_blk = c_blk[p+1];
      assign nb_vld = c_vld[p+1];
      assign nb_cnt = c_cnt[p+1];
    end

    lbc_cell #(
      .SLOTS    (SLOTS),
      .REF_BITS (REF_BITS),
      .POS      (p)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .eval_i   (state_q == S_EVAL),
      .apply_i  (apply_go),
      .cmd_i    (cmd),
      .rel_id_i (rel_id),
      .sel_i    (sel[p]),
      .shift_i  (shift[p]),
      .nb_id_i  (nb_id),
      .nb_dev_i (nb_dev),
      .nb_blk_i (nb_blk),
      .nb_vld_i (nb_vld),
      .nb_cnt_i (nb_cnt),
      .id_o     (c_id[p]),
      .dev_o    (c_dev[p]),
      .blk_o    (c_blk[p]),
      .vld_o    (c_vld[p]),
      .cnt_o    (c_cnt[p]),
      .match_o  (match[p]),
      .zero_o   (zero[p]),
      .idhit_o  (idhit[p])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: if (apply_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (apply_go) begin
      out_rsp_q <= rsp;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one cell selected");

  a_eval_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |=> state_q == S_APPLY)
    else $error("compare cycle not followed by update");

  a_rsp_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_APPLY))
    else $error("response without update cycle");

  a_move_has_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_go && cmd.kind == KIND_MOVE) |-> shift[SLOTS-1])
    else $error("move without top cell load");

endmodule
